// ===== sv/canonical_huffman_code_table_core_defines.svh =====
// assertion macros shared by the checker
`ifndef CANONICAL_HUFFMAN_CODE_TABLE_CORE_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CHCT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("code table check failed");

// next-cycle implication, disabled while reset is low
`define CHCT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("code table check failed");

`endif

// ===== sv/chct_pkg.sv =====
package chct_pkg;

    localparam int SYMBOL_CAP_DEF  = 512;
    localparam int TABLE_DEPTH     = 512;
    localparam int MAX_LENGTH      = 15;
    localparam int LEN_SLOTS       = 16;

    localparam int SYM_W      = 9;
    localparam int LEN_W      = 4;
    localparam int CODE_W     = 16;
    localparam int CNT_W      = 10;
    localparam int SIU_W      = 10;
    localparam int MCL_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int RESET_SYMBOLS = 512;
    localparam int RESET_MAX_LEN = 15;

    typedef enum logic [1:0] {
        MODE_SET,
        MODE_BUILD,
        MODE_LOOKUP,
        MODE_CLEAR
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_SYMBOL,
        STAT_BAD_LENGTH,
        STAT_NOT_BUILT
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOLS_IN_USE,
        REG_MAX_CODE_LENGTH
    } reg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_length;
        logic              present;
        status_t           status;
    } result_t;

endpackage

// ===== sv/canonical_huffman_code_table_core.sv =====
// Canonical Huffman code table. A set word writes one symbol's code length, a clear word
// zeroes all lengths, a build word derives DEFLATE-style canonical codes from the lengths and
// a lookup word returns a symbol's code, length and present flag; every input word gives one
// result word. Lengths and codes live in two single-port-read memories of min(SYMBOL_CAP, 512)
// entries with a registered read. With the result side ready, a set word and a rejected
// lookup are answered from idle, and a lookup goes through the memory read, then the output
// register. A build walks the length memory twice, once to count lengths and once to hand
// out codes, with one pass over the lengths between to form the first code of each length;
// each walk covers the active alphabet. A clear sweeps the length memory one entry a cycle.
// After reset the same sweep runs with s_ready low; configuration writes are taken
// throughout. A write to either mapped configuration register, an accepted set or a clear
// invalidates built codes.
module canonical_huffman_code_table_core #(
    parameter int SYMBOL_CAP = chct_pkg::SYMBOL_CAP_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [chct_pkg::SYM_W-1:0]       s_symbol,
    input  logic [chct_pkg::LEN_W-1:0]       s_sym_len,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [chct_pkg::CODE_W-1:0]      m_code,
    output logic [chct_pkg::LEN_W-1:0]       m_code_length,
    output logic                             m_present,
    output logic [1:0]                       m_status,
    input  logic                             cfg_wr_en,
    input  logic [chct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chct_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int DEPTH = (SYMBOL_CAP < chct_pkg::TABLE_DEPTH) ? SYMBOL_CAP
                                                                : chct_pkg::TABLE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LVL_W = $clog2(chct_pkg::LEN_SLOTS);
    localparam int SIU_W = chct_pkg::SIU_W;
    localparam int LEN_W = chct_pkg::LEN_W;
    localparam int CW    = chct_pkg::CODE_W;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_CLEAR,
        ST_COUNT,
        ST_FIRST,
        ST_ASSIGN,
        ST_RESP
    } state_t;

    // control and output registers
    state_t              state_reg, state_next;
    logic [AW:0]         ptr_reg, ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]       rd_addr_d_reg, rd_addr_d_next;
    logic                built_reg, built_next;
    logic [SIU_W-1:0]    siu_reg, siu_next;
    logic [chct_pkg::MCL_W-1:0] mcl_reg, mcl_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [CW-1:0]       run_reg, run_next;
    chct_pkg::result_t   res_reg, res_next;
    chct_pkg::result_t   out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // memories and their read registers
    logic [LEN_W-1:0]    len_mem  [DEPTH];
    logic [CW-1:0]       code_mem [DEPTH];
    logic [LEN_W-1:0]    len_rdata_reg;
    logic [CW-1:0]       code_rdata_reg;

    // per-length counts and next codes
    logic [chct_pkg::CNT_W-1:0] cnt_reg [chct_pkg::LEN_SLOTS];
    logic [CW-1:0]              nxt_reg [chct_pkg::LEN_SLOTS];

    logic [AW-1:0]       rd_addr;
    logic                len_we;
    logic [AW-1:0]       len_waddr;
    logic [LEN_W-1:0]    len_wdata;
    logic                code_we;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                nxt_wr;
    logic                nxt_inc;
    logic [LVL_W-1:0]    cnt_idx;
    logic [LVL_W-1:0]    nxt_idx;
    logic [chct_pkg::CNT_W-1:0] cnt_rd;
    logic [CW-1:0]       nxt_rd;
    logic [CW-1:0]       run_sum;
    logic [CW-1:0]       run_new;

    logic [SIU_W-1:0]    sym_lim;
    logic [LEN_W-1:0]    len_lim;
    logic                sym_bad;
    logic                len_bad;
    logic                walk_issue;
    logic                out_free;
    logic                len_nz;
    chct_pkg::result_t   imm;
    logic                imm_vld;

    assign sym_lim  = (siu_reg > SIU_W'(DEPTH)) ? SIU_W'(DEPTH) : siu_reg;
    assign len_lim  = (mcl_reg > LEN_W'(chct_pkg::MAX_LENGTH)) ? LEN_W'(chct_pkg::MAX_LENGTH)
                                                               : mcl_reg;
    assign sym_bad  = SIU_W'(s_symbol) >= sym_lim;
    assign len_bad  = s_sym_len > len_lim;
    assign walk_issue = SIU_W'(ptr_reg) < sym_lim;
    assign out_free = !m_valid_reg || m_ready;
    assign len_nz   = len_rdata_reg != '0;

    assign rd_addr = (state_reg == ST_COUNT || state_reg == ST_ASSIGN) ? ptr_reg[AW-1:0]
                                                                       : s_symbol[AW-1:0];

    // one read index each into the count and next-code arrays
    assign cnt_idx = (state_reg == ST_FIRST) ? lvl_reg - 1'b1 : len_rdata_reg;
    assign nxt_idx = (state_reg == ST_FIRST) ? lvl_reg : len_rdata_reg;
    assign cnt_rd  = cnt_reg[cnt_idx];
    assign nxt_rd  = nxt_reg[nxt_idx];
    assign run_sum = run_reg + CW'(cnt_rd);
    assign run_new = run_sum << 1;

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        rd_addr_d_next = ptr_reg[AW-1:0];
        built_next     = built_reg;
        siu_next       = siu_reg;
        mcl_next       = mcl_reg;
        lvl_next       = lvl_reg;
        run_next       = run_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        len_we         = 1'b0;
        len_waddr      = ptr_reg[AW-1:0];
        len_wdata      = '0;
        code_we        = 1'b0;
        cnt_clr        = 1'b0;
        cnt_inc        = 1'b0;
        nxt_wr         = 1'b0;
        nxt_inc        = 1'b0;
        imm            = '{code: '0, code_length: '0, present: 1'b0,
                           status: chct_pkg::STAT_OK};
        imm_vld        = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                len_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg[AW-1:0] == AW'(DEPTH - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                    imm_vld    = (state_reg == ST_CLEAR);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (chct_pkg::mode_t'(s_mode))
                        chct_pkg::MODE_SET: begin
                            imm_vld = 1'b1;
                            if (sym_bad) begin
                                imm.status = chct_pkg::STAT_BAD_SYMBOL;
                            end else if (len_bad) begin
                                imm.status = chct_pkg::STAT_BAD_LENGTH;
                            end else begin
                                len_we     = 1'b1;
                                len_waddr  = s_symbol[AW-1:0];
                                len_wdata  = s_sym_len;
                                built_next = 1'b0;
                            end
                        end
                        chct_pkg::MODE_BUILD: begin
                            cnt_clr    = 1'b1;
                            ptr_next   = '0;
                            state_next = ST_COUNT;
                        end
                        chct_pkg::MODE_LOOKUP: begin
                            if (sym_bad) begin
                                imm_vld    = 1'b1;
                                imm.status = chct_pkg::STAT_BAD_SYMBOL;
                            end else if (!built_reg) begin
                                imm_vld    = 1'b1;
                                imm.status = chct_pkg::STAT_NOT_BUILT;
                            end else begin
                                state_next = ST_LOOK;
                            end
                        end
                        chct_pkg::MODE_CLEAR: begin
                            ptr_next   = '0;
                            built_next = 1'b0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                imm_vld          = 1'b1;
                state_next       = ST_IDLE;
                imm.present      = len_nz;
                imm.code_length  = len_rdata_reg;
                imm.code         = len_nz ? code_rdata_reg : '0;
            end
            ST_COUNT: begin
                rd_vld_next = walk_issue;
                if (walk_issue) begin
                    ptr_next = ptr_reg + 1'b1;
                end
                cnt_inc = rd_vld_reg && len_nz;
                if (!walk_issue && !rd_vld_reg) begin
                    lvl_next   = LVL_W'(1);
                    run_next   = '0;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // first code of this length from the previous length's first code and count
                nxt_wr   = 1'b1;
                run_next = run_new;
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == LVL_W'(chct_pkg::LEN_SLOTS - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN: begin
                rd_vld_next = walk_issue;
                if (walk_issue) begin
                    ptr_next = ptr_reg + 1'b1;
                end
                code_we = rd_vld_reg && len_nz;
                nxt_inc = rd_vld_reg && len_nz;
                if (!walk_issue && !rd_vld_reg) begin
                    built_next = 1'b1;
                    imm_vld    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result goes straight to the output register when it is free, else it waits
        if (imm_vld) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                out_next     = imm;
            end else begin
                res_next   = imm;
                state_next = ST_RESP;
            end
        end

        if (cfg_wr_en) begin
            case (chct_pkg::reg_index_t'(cfg_index))
                chct_pkg::REG_SYMBOLS_IN_USE: begin
                    siu_next   = cfg_wr_data[SIU_W-1:0];
                    built_next = 1'b0;
                end
                chct_pkg::REG_MAX_CODE_LENGTH: begin
                    mcl_next   = cfg_wr_data[chct_pkg::MCL_W-1:0];
                    built_next = 1'b0;
                end
                default: begin
                    siu_next = siu_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            built_reg   <= 1'b0;
            siu_reg     <= SIU_W'(chct_pkg::RESET_SYMBOLS);
            mcl_reg     <= chct_pkg::MCL_W'(chct_pkg::RESET_MAX_LEN);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            rd_addr_d_reg <= rd_addr_d_next;
            built_reg     <= built_next;
            siu_reg       <= siu_next;
            mcl_reg       <= mcl_next;
            lvl_reg       <= lvl_next;
            run_reg       <= run_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata_reg <= len_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (code_we) begin
            code_mem[rd_addr_d_reg] <= nxt_rd;
        end
        code_rdata_reg <= code_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_clr) begin
            for (int i = 0; i < chct_pkg::LEN_SLOTS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cnt_inc) begin
            cnt_reg[cnt_idx] <= cnt_rd + 1'b1;
        end
        if (nxt_wr) begin
            nxt_reg[nxt_idx] <= run_new;
        end else if (nxt_inc) begin
            nxt_reg[nxt_idx] <= nxt_rd + 1'b1;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_code        = out_reg.code;
    assign m_code_length = out_reg.code_length;
    assign m_present     = out_reg.present;
    assign m_status      = out_reg.status;

endmodule

// ===== sv/chct_checker.sv =====
`include "canonical_huffman_code_table_core_defines.svh"

module chct_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [1:0]                   s_mode,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [chct_pkg::CODE_W-1:0]  m_code,
    input logic [chct_pkg::LEN_W-1:0]   m_code_length,
    input logic                         m_present,
    input logic [1:0]                   m_status
);

    // a stalled result word holds
    `CHCT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_code) && $stable(m_code_length) && $stable(m_present) && $stable(m_status))

    // a word without a present symbol carries no code
    `CHCT_ASSERT_IMP(a_absent_zero, aclk, aresetn, m_valid && !m_present, m_code == '0 && m_code_length == '0)

    // a present symbol only comes with ok status and a nonzero length
    `CHCT_ASSERT_IMP(a_present_ok, aclk, aresetn, m_valid && m_present, m_status == chct_pkg::STAT_OK && m_code_length != '0)

    // build and clear walk the length memory, so input stalls right after them
    `CHCT_ASSERT_NXT(a_walk_blocks, aclk, aresetn, s_valid && s_ready && (s_mode == chct_pkg::MODE_BUILD || s_mode == chct_pkg::MODE_CLEAR), !s_ready)

endmodule

bind canonical_huffman_code_table_core chct_checker u_chct_checker (.*);

// ===== tb/canonical_huffman_code_table_core_test.sv =====
module canonical_huffman_code_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chct_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 1700;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 80;
    localparam int MAX_GAP      = 11;
    localparam int REPORT_LINES = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef enum int unsigned {
        GAPS_NONE,
        GAPS_FULL,
        GAPS_SPARSE
    } gap_style_t;

    typedef struct packed {
        mode_t             mode;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  sym_len;
    } table_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_mode = 2'd0;
    logic [SYM_W-1:0]       s_symbol = '0;
    logic [LEN_W-1:0]       s_sym_len = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [CODE_W-1:0]      m_code;
    logic [LEN_W-1:0]       m_code_length;
    logic                   m_present;
    logic [1:0]             m_status;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    canonical_huffman_code_table_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_symbol      (s_symbol),
        .s_sym_len     (s_sym_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code        (m_code),
        .m_code_length (m_code_length),
        .m_present     (m_present),
        .m_status      (m_status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // shadow copy of the code table state
    logic [SIU_W-1:0]   table_symbols = SIU_W'(RESET_SYMBOLS);
    logic [MCL_W-1:0]   max_len = MCL_W'(RESET_MAX_LEN);
    logic [LEN_W-1:0]   len_mem [TABLE_DEPTH];
    logic [CODE_W-1:0]  code_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]   len_count [LEN_SLOTS];
    logic [CODE_W-1:0]  code_cursor [LEN_SLOTS];
    bit                 codes_valid = 1'b0;

    table_word_t  table_words_pending [$];
    result_t      due_results [$];
    table_word_t  bus_word;
    table_word_t  next_word;
    result_t      due_head;

    gap_style_t   src_gap_mode = GAPS_NONE;
    gap_style_t   sink_gap_mode = GAPS_NONE;
    int unsigned  src_hold = 0;
    int unsigned  sink_hold = 0;
    int unsigned  sink_wait;
    int unsigned  words_queued = 0;
    int unsigned  words_accepted = 0;
    int unsigned  results_seen = 0;
    int unsigned  error_count = 0;
    longint unsigned cycle_count = 0;
    longint unsigned cycle_budget = 64'(8 * (TABLE_DEPTH + TAIL_CYCLES) + 4000);

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    function automatic int unsigned draw_gap(input gap_style_t style);
        case (style)
            GAPS_NONE: return 0;
            GAPS_FULL: return $urandom_range(0, MAX_GAP);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
        endcase
    endfunction

    function automatic result_t predict_table_result(input table_word_t w);
        result_t r;
        int unsigned sym_lim;
        int unsigned len_lim;
        logic [CODE_W-1:0] base_code;
        r = '0;
        sym_lim = 32'(table_symbols);
        if (sym_lim > SYMBOL_CAP_DEF) sym_lim = SYMBOL_CAP_DEF;
        if (sym_lim > TABLE_DEPTH) sym_lim = TABLE_DEPTH;
        len_lim = 32'(max_len);
        if (len_lim > MAX_LENGTH) len_lim = MAX_LENGTH;
        case (w.mode)
            MODE_SET: begin
                if (w.symbol >= sym_lim) begin
                    r.status = STAT_BAD_SYMBOL;
                end else if (w.sym_len > len_lim) begin
                    r.status = STAT_BAD_LENGTH;
                end else begin
                    len_mem[w.symbol] = w.sym_len;
                    codes_valid = 1'b0;
                end
            end
            MODE_BUILD: begin
                for (int l = 0; l < LEN_SLOTS; l++) len_count[l] = '0;
                for (int s = 0; s < sym_lim; s++)
                    len_count[len_mem[s]] = len_count[len_mem[s]] + 1'b1;
                len_count[0] = '0;
                base_code = '0;
                code_cursor[0] = '0;
                // first code of each length, kept to 16 bits
                for (int l = 1; l < LEN_SLOTS; l++) begin
                    base_code = (base_code + {{(CODE_W-CNT_W){1'b0}}, len_count[l-1]}) << 1;
                    code_cursor[l] = base_code;
                end
                for (int s = 0; s < sym_lim; s++) begin
                    if (len_mem[s] != 0) begin
                        code_mem[s] = code_cursor[len_mem[s]];
                        code_cursor[len_mem[s]] = code_cursor[len_mem[s]] + 1'b1;
                    end
                end
                codes_valid = 1'b1;
            end
            MODE_LOOKUP: begin
                if (w.symbol >= sym_lim) begin
                    r.status = STAT_BAD_SYMBOL;
                end else if (!codes_valid) begin
                    r.status = STAT_NOT_BUILT;
                end else if (len_mem[w.symbol] != 0) begin
                    r.code = code_mem[w.symbol];
                    r.code_length = len_mem[w.symbol];
                    r.present = 1'b1;
                end
            end
            default: begin
                for (int s = 0; s < TABLE_DEPTH; s++) len_mem[s] = '0;
                codes_valid = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < REPORT_LINES)
            $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got,
                     want);
        error_count++;
    endtask

    task automatic queue_word(input mode_t mode, input logic [SYM_W-1:0] symbol,
                              input logic [LEN_W-1:0] sym_len);
        table_word_t w;
        int unsigned busy;
        w.mode = mode;
        w.symbol = symbol;
        w.sym_len = sym_len;
        if (mode == MODE_BUILD) busy = 2 * TABLE_DEPTH + 24;
        else if (mode == MODE_CLEAR) busy = TABLE_DEPTH + 4;
        else busy = 4;
        table_words_pending.push_back(w);
        words_queued++;
        cycle_budget += 4 * (busy + 2 * MAX_GAP + 4);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SYMBOLS_IN_USE) begin
            table_symbols = data[SIU_W-1:0];
            codes_valid = 1'b0;
        end else if (idx == REG_MAX_CODE_LENGTH) begin
            max_len = data[MCL_W-1:0];
            codes_valid = 1'b0;
        end
        cycle_budget += 40;
        @(negedge aclk);
    endtask

    task automatic wait_table_idle();
        while (!(words_accepted == words_queued && due_results.size() == 0))
            @(posedge aclk);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        cycle_budget += 40;
    endtask

    // word driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_hold <= 0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.push_back(predict_table_result(bus_word));
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_hold > 0) begin
                    s_valid <= 1'b0;
                    src_hold <= src_hold - 1;
                end else if (table_words_pending.size() > 0) begin
                    next_word = table_words_pending.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= next_word.mode;
                    s_symbol <= next_word.symbol;
                    s_sym_len <= next_word.sym_len;
                    bus_word <= next_word;
                    src_hold <= draw_gap(src_gap_mode);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else begin
            sink_wait = sink_hold;
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch("word with no result due", 32'd1, 32'd0);
                end else begin
                    due_head = due_results.pop_front();
                    if (m_code !== due_head.code)
                        report_mismatch("code", 32'(m_code), 32'(due_head.code));
                    if (m_code_length !== due_head.code_length)
                        report_mismatch("code_length", 32'(m_code_length),
                                        32'(due_head.code_length));
                    if (m_present !== due_head.present)
                        report_mismatch("present", 32'(m_present), 32'(due_head.present));
                    if (m_status !== due_head.status)
                        report_mismatch("status", 32'(m_status), 32'(due_head.status));
                end
                sink_wait = draw_gap(sink_gap_mode);
            end
            if (sink_wait > 0) begin
                m_ready <= 1'b0;
                sink_hold <= sink_wait - 1;
            end else begin
                m_ready <= 1'b1;
                sink_hold <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned sym_lim;
        int unsigned len_lim;
        int unsigned pick;
        int unsigned n_rounds;
        int unsigned n_sets;
        int unsigned n_looks;
        int unsigned directed_words;
        logic [SIU_W-1:0] siu_val;
        logic [MCL_W-1:0] mcl_val;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] blen;
        logic [SYM_W-1:0] touched [$];

        for (int s = 0; s < TABLE_DEPTH; s++) len_mem[s] = '0;
        for (int l = 0; l < LEN_SLOTS; l++) begin
            len_count[l] = '0;
            code_cursor[l] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, lookup before any build, unused symbol, stale codes, empty build
        queue_word(MODE_LOOKUP, 9'd0, 4'd0);
        queue_word(MODE_SET, 9'd0, 4'd15);
        queue_word(MODE_SET, 9'd511, 4'd1);
        queue_word(MODE_SET, 9'd2, 4'd15);
        queue_word(MODE_SET, 9'd1, 4'd0);
        queue_word(MODE_BUILD, 9'd0, 4'd0);
        queue_word(MODE_LOOKUP, 9'd0, 4'd15);
        queue_word(MODE_LOOKUP, 9'd511, 4'd0);
        queue_word(MODE_LOOKUP, 9'd1, 4'd0);
        queue_word(MODE_SET, 9'd3, 4'd2);
        queue_word(MODE_LOOKUP, 9'd0, 4'd0);
        queue_word(MODE_CLEAR, 9'd511, 4'd15);
        queue_word(MODE_BUILD, 9'd511, 4'd15);
        queue_word(MODE_LOOKUP, 9'd511, 4'd0);
        wait_table_idle();

        // one symbol, no length allowed; symbol check wins over length check
        write_register(REG_SYMBOLS_IN_USE, 10'd1);
        write_register(REG_MAX_CODE_LENGTH, 10'h3F0);
        queue_word(MODE_SET, 9'd0, 4'd1);
        queue_word(MODE_SET, 9'd1, 4'd9);
        queue_word(MODE_LOOKUP, 9'd1, 4'd0);
        queue_word(MODE_BUILD, 9'd0, 4'd0);
        queue_word(MODE_LOOKUP, 9'd0, 4'd0);
        wait_table_idle();

        // unmapped index must leave the built codes alone
        write_register(REG_UNMAPPED_LO, 10'h3FF);
        queue_word(MODE_LOOKUP, 9'd0, 4'd0);
        wait_table_idle();

        write_register(REG_SYMBOLS_IN_USE, 10'd0);
        queue_word(MODE_SET, 9'd0, 4'd0);
        queue_word(MODE_LOOKUP, 9'd0, 4'd0);
        queue_word(MODE_BUILD, 9'd0, 4'd0);
        wait_table_idle();

        // oversized alphabet, then lengths left above a lowered limit
        write_register(REG_SYMBOLS_IN_USE, 10'd1023);
        write_register(REG_MAX_CODE_LENGTH, 10'd15);
        queue_word(MODE_SET, 9'd511, 4'd15);
        queue_word(MODE_SET, 9'd10, 4'd1);
        queue_word(MODE_SET, 9'd11, 4'd1);
        queue_word(MODE_SET, 9'd12, 4'd1);
        wait_table_idle();
        write_register(REG_MAX_CODE_LENGTH, 10'd3);
        queue_word(MODE_SET, 9'd13, 4'd4);
        queue_word(MODE_BUILD, 9'd0, 4'd0);
        queue_word(MODE_LOOKUP, 9'd511, 4'd0);
        queue_word(MODE_LOOKUP, 9'd12, 4'd0);
        wait_table_idle();
        directed_words = words_queued;

        while (words_queued - directed_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) siu_val = 10'd512;
            else if (pick == 1) siu_val = 10'd1023;
            else if (pick == 2) siu_val = SIU_W'($urandom_range(0, 1023));
            else if (pick == 3) siu_val = SIU_W'($urandom_range(0, 1));
            else siu_val = SIU_W'($urandom_range(2, 40));
            pick = $urandom_range(0, 9);
            if (pick == 0) mcl_val = 4'd0;
            else if (pick == 1) mcl_val = 4'd1;
            else if (pick < 5) mcl_val = 4'd15;
            else mcl_val = MCL_W'($urandom_range(1, 15));

            pick = $urandom_range(0, 9);
            if (pick != 0 && pick != 2)
                write_register(REG_SYMBOLS_IN_USE, siu_val);
            if (pick != 0 && pick != 1)
                write_register(REG_MAX_CODE_LENGTH,
                               {6'($urandom_range(0, 63)), mcl_val});
            if (pick == 3)
                write_register($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                               CFG_DATA_W'($urandom_range(0, 1023)));

            src_gap_mode = gap_style_t'($urandom_range(0, 2));
            sink_gap_mode = gap_style_t'($urandom_range(0, 2));
            sym_lim = (32'(table_symbols) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(table_symbols);
            len_lim = (32'(max_len) > MAX_LENGTH) ? MAX_LENGTH : 32'(max_len);
            touched.delete();
            n_rounds = $urandom_range(1, 4);

            for (int rnd = 0; rnd < n_rounds; rnd++) begin
                if (sym_lim == 0) begin
                    // every symbol out of range: noise only
                    for (int i = 0; i < 6; i++)
                        queue_word(mode_t'($urandom_range(0, 3)),
                                   SYM_W'($urandom_range(0, 511)),
                                   LEN_W'($urandom_range(0, 15)));
                end else begin
                    n_sets = $urandom_range(1, (sym_lim < 20) ? sym_lim : 20);
                    for (int i = 0; i < n_sets; i++) begin
                        sym = SYM_W'($urandom_range(0, sym_lim - 1));
                        pick = $urandom_range(0, 99);
                        if (len_lim > 0 && pick < 80) blen = LEN_W'($urandom_range(1, len_lim));
                        else if (pick < 90) blen = 4'd0;
                        else blen = LEN_W'($urandom_range(0, 15));
                        touched.push_back(sym);
                        queue_word(MODE_SET, sym, blen);
                    end
                    if ($urandom_range(0, 9) == 0)
                        queue_word(mode_t'($urandom_range(0, 3)),
                                   SYM_W'($urandom_range(0, 511)),
                                   LEN_W'($urandom_range(0, 15)));
                    if ($urandom_range(0, 9) == 0)
                        queue_word(MODE_LOOKUP, SYM_W'($urandom_range(0, sym_lim - 1)),
                                   LEN_W'($urandom_range(0, 15)));
                    queue_word(MODE_BUILD, SYM_W'($urandom_range(0, 511)),
                               LEN_W'($urandom_range(0, 15)));
                    n_looks = $urandom_range(3, 14);
                    for (int i = 0; i < n_looks; i++) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6) sym = touched[$urandom_range(0, touched.size() - 1)];
                        else if (pick < 9) sym = SYM_W'($urandom_range(0, sym_lim - 1));
                        else sym = SYM_W'($urandom_range(0, 511));
                        queue_word(MODE_LOOKUP, sym, LEN_W'($urandom_range(0, 15)));
                    end
                    if ($urandom_range(0, 19) == 0) begin
                        queue_word(MODE_CLEAR, SYM_W'($urandom_range(0, 511)),
                                   LEN_W'($urandom_range(0, 15)));
                        queue_word(MODE_LOOKUP, SYM_W'($urandom_range(0, sym_lim - 1)),
                                   LEN_W'($urandom_range(0, 15)));
                    end
                end
            end
            wait_table_idle();
        end

        src_gap_mode = GAPS_NONE;
        sink_gap_mode = GAPS_NONE;
        wait_table_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
